FILE: rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the streaming SHA-1 block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

    localparam logic [1:0] OP_ABSORB  = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [1:0] {
        CMD_ABSORB  = 2'd0,
        CMD_FINISH  = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sha1_stream_hash_top.sv
// ----------------------------------------------------------------------------
// sha1_stream_hash_top
// Streaming SHA-1 hash over a byte stream.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat per op. Absorb (op 0) carries one message
// byte; finish (op 1) pads and closes the message and returns five
// digest beats on m_*, word 0 first, m_last_word on word 4; restart
// (op 2) reloads the initial hash. Op 3 is dropped. Absorbs after a
// finish are dropped; a repeated finish re-sends the same digest.
// A two-entry queue sits between the input port and the hash engine.
// An absorb writes one byte into the word window; the 64th byte of a
// block starts the 80 rounds of the single round unit and the final
// add; the engine takes no command meanwhile. Finish pads, runs one
// or two blocks of rounds and sends the digest. The engine holds
// each digest beat until m_ready; input beats queue up to two deep and
// then s_ready drops. Reset (aresetn low, synchronous) empties the
// queue and loads the initial hash; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hash_top
    import sha1_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    logic q_valid, q_ready;
    cmd_t q_cmd;

    sha1_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .s_data_byte(s_data_byte),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    sha1_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_digest_word(m_digest_word), .m_word_index(m_word_index),
        .m_last_word(m_last_word)
    );

endmodule

`default_nettype wire

FILE: rtl/core/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front
// Accepts input beats, drops unused op codes and pushes commands to a
// two-entry queue read by the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_front
    import sha1_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [7:0] s_data_byte,
    output logic            q_valid,
    input  wire logic       q_ready,
    output cmd_t            q_cmd
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop, keep;
    cmd_t       cmd_in;

    assign s_ready = (count_reg != 2'd2);
    assign keep    = (s_op == OP_ABSORB) || (s_op == OP_FINISH) || (s_op == OP_RESTART);
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        cmd_in.data = s_data_byte;
        case (s_op)
            OP_FINISH:  cmd_in.kind = CMD_FINISH;
            OP_RESTART: cmd_in.kind = CMD_RESTART;
            default:    cmd_in.kind = CMD_ABSORB;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha1_engine.sv
// ----------------------------------------------------------------------------
// sha1_engine
// Packs bytes into a 16-word window, runs one compression round a cycle,
// applies padding and streams the five digest words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_engine
    import sha1_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire cmd_t        q_cmd,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_PAD   = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_ADD   = 5'b10000
    } state_t;

    state_t       state_reg;
    logic [31:0]  h_reg [5];
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]   fill_reg;
    logic [63:0]  msg_reg;
    logic         fin_reg;
    logic [6:0]   rnd_reg;
    logic         pad_more_reg;   // second padding block still to go
    logic         emit_after_reg; // emit digest once compression ends
    logic [2:0]   idx_reg;

    logic [31:0]  f, k, t, wnew, wcur, in_word;
    logic [63:0]  bits;

    assign bits    = {msg_reg[60:0], 3'b000};
    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign m_digest_word = h_reg[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == 3'd4);

    assign wcur = w_reg[0];
    assign wnew = {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                   w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};

    always_comb begin
        if (rnd_reg < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K0;
        end else if (rnd_reg < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K1;
        end else if (rnd_reg < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K2;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wcur;
    end

    // merge the byte into its word lane
    always_comb begin
        in_word = w_reg[fill_reg[5:2]];
        case (fill_reg[1:0])
            2'd0:    in_word = {q_cmd.data, 24'd0};
            2'd1:    in_word[23:16] = q_cmd.data;
            2'd2:    in_word[15:8]  = q_cmd.data;
            default: in_word[7:0]   = q_cmd.data;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
            h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
            fill_reg <= 6'd0;
            msg_reg  <= 64'd0;
            fin_reg  <= 1'b0;
            rnd_reg  <= 7'd0;
            idx_reg  <= 3'd0;
            pad_more_reg   <= 1'b0;
            emit_after_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        case (q_cmd.kind)
                            CMD_ABSORB: begin
                                if (!fin_reg) begin
                                    w_reg[fill_reg[5:2]] <= in_word;
                                    msg_reg  <= msg_reg + 64'd1;
                                    fill_reg <= fill_reg + 6'd1;
                                    if (fill_reg == 6'd63) begin
                                        a_reg <= h_reg[0]; b_reg <= h_reg[1];
                                        c_reg <= h_reg[2]; d_reg <= h_reg[3];
                                        e_reg <= h_reg[4];
                                        rnd_reg <= 7'd0;
                                        emit_after_reg <= 1'b0;
                                        pad_more_reg   <= 1'b0;
                                        state_reg <= ST_ROUND;
                                    end
                                end
                            end
                            CMD_FINISH: begin
                                idx_reg <= 3'd0;
                                if (fin_reg) begin
                                    state_reg <= ST_EMIT;
                                end else begin
                                    state_reg <= ST_PAD;
                                end
                            end
                            CMD_RESTART: begin
                                h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT;
                                h_reg[2] <= H2_INIT; h_reg[3] <= H3_INIT;
                                h_reg[4] <= H4_INIT;
                                fill_reg <= 6'd0;
                                msg_reg  <= 64'd0;
                                fin_reg  <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PAD: begin
                    // stale bytes beyond fill are overwritten here
                    for (int i = 0; i < 16; i++) begin
                        if (i > int'(fill_reg[5:2]) && (i < 14 || fill_reg >= 6'd56))
                            w_reg[i] <= 32'd0;
                    end
                    case (fill_reg[1:0])
                        2'd0: w_reg[fill_reg[5:2]] <= {PAD_BYTE, 24'd0};
                        2'd1: w_reg[fill_reg[5:2]][23:0] <= {PAD_BYTE, 16'd0};
                        2'd2: w_reg[fill_reg[5:2]][15:0] <= {PAD_BYTE, 8'd0};
                        default: w_reg[fill_reg[5:2]][7:0] <= PAD_BYTE;
                    endcase
                    if (fill_reg < 6'd56) begin
                        w_reg[14] <= bits[63:32];
                        w_reg[15] <= bits[31:0];
                        pad_more_reg <= 1'b0;
                    end else begin
                        pad_more_reg <= 1'b1;
                    end
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                    rnd_reg <= 7'd0;
                    emit_after_reg <= 1'b1;
                    fill_reg <= 6'd0;
                    fin_reg  <= 1'b1;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg;
                    a_reg <= t;
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd79) state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    if (pad_more_reg) begin
                        for (int i = 0; i < 14; i++) w_reg[i] <= 32'd0;
                        w_reg[14] <= bits[63:32];
                        w_reg[15] <= bits[31:0];
                        a_reg <= h_reg[0] + a_reg; b_reg <= h_reg[1] + b_reg;
                        c_reg <= h_reg[2] + c_reg; d_reg <= h_reg[3] + d_reg;
                        e_reg <= h_reg[4] + e_reg;
                        rnd_reg <= 7'd0;
                        pad_more_reg <= 1'b0;
                        state_reg <= ST_ROUND;
                    end else if (emit_after_reg) begin
                        idx_reg <= 3'd0;
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd4) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// Port-level checks of the SHA-1 block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_digest_word,
    input wire logic [2:0]  m_word_index,
    input wire logic        m_last_word
);

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 3'd4)))
        else $error("last_word mismatch");

    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word_index <= 3'd4))
        else $error("word index out of range");

    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=>
            (m_valid && m_word_index == $past(m_word_index) + 3'd1))
        else $error("digest beats not consecutive");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_digest_word)))
        else $error("stalled beat changed");

endmodule

bind sha1_stream_hash_top sha1_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_digest_word(m_digest_word), .m_word_index(m_word_index),
    .m_last_word(m_last_word)
);

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bytes, finish, restart and unused ops into the SHA-1 block and checks
// every digest beat against an in-bench SHA-1 predictor.
// ----------------------------------------------------------------------------
`default_nettype none

class digest_board;
    logic [31:0] hw [5];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] nbytes;
    bit          closed;
    logic [31:0] exp_word [$];
    logic [2:0]  exp_idx [$];
    bit          exp_last [$];
    int          errors;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        hw[0] = sha1_pkg::H0_INIT;
        hw[1] = sha1_pkg::H1_INIT;
        hw[2] = sha1_pkg::H2_INIT;
        hw[3] = sha1_pkg::H3_INIT;
        hw[4] = sha1_pkg::H4_INIT;
        foreach (blk[i]) blk[i] = 8'h00;
        fill = 0;
        nbytes = 64'd0;
        closed = 1'b0;
    endfunction

    function void compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 80; i++) begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = hw[0]; b = hw[1]; c = hw[2]; d = hw[3]; e = hw[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = sha1_pkg::K0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = sha1_pkg::K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
            end else begin
                f = b ^ c ^ d; k = sha1_pkg::K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        hw[0] += a; hw[1] += b; hw[2] += c; hw[3] += d; hw[4] += e;
    endfunction

    function void note_beat(logic [1:0] op, logic [7:0] data);
        logic [63:0] bits;
        int pos;
        if (op == sha1_pkg::OP_ABSORB) begin
            if (closed) return;
            blk[fill] = data;
            nbytes += 64'd1;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        end else if (op == sha1_pkg::OP_FINISH) begin
            if (!closed) begin
                bits = nbytes << 3;
                pos = fill;
                blk[pos++] = sha1_pkg::PAD_BYTE;
                if (pos > 56) begin
                    while (pos < 64) blk[pos++] = 8'h00;
                    compress();
                    pos = 0;
                end
                while (pos < 56) blk[pos++] = 8'h00;
                for (int i = 0; i < 8; i++) blk[56+i] = bits[8*(7-i) +: 8];
                compress();
                fill = 0;
                closed = 1'b1;
            end
            for (int i = 0; i < 5; i++) begin
                exp_word.push_back(hw[i]);
                exp_idx.push_back(i[2:0]);
                exp_last.push_back(i == 4);
            end
        end else if (op == sha1_pkg::OP_RESTART) begin
            clear();
        end
    endfunction

    function void check_beat(logic [31:0] wd, logic [2:0] idx, logic last);
        logic [31:0] ew;
        logic [2:0]  ei;
        bit          el;
        if (exp_word.size() == 0) begin
            $display("%0t: unexpected digest beat word=%h idx=%0d last=%0d",
                     $time, wd, idx, last);
            errors++;
            return;
        end
        ew = exp_word.pop_front();
        ei = exp_idx.pop_front();
        el = exp_last.pop_front();
        if (wd !== ew) begin
            $display("%0t: digest_word expected %h actual %h", $time, ew, wd);
            errors++;
        end
        if (idx !== ei) begin
            $display("%0t: word_index expected %0d actual %0d", $time, ei, idx);
            errors++;
        end
        if (last !== el) begin
            $display("%0t: last_word expected %0d actual %0d", $time, el, last);
            errors++;
        end
    endfunction

    function int pending();
        return exp_word.size();
    endfunction
endclass

module testbench;
    import sha1_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_ABSORB;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    digest_board board = new();
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    sha1_stream_hash_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_digest_word(m_digest_word),
        .m_word_index(m_word_index), .m_last_word(m_last_word)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_beat(m_digest_word, m_word_index, m_last_word);
        if (aresetn && !hold_off)
            m_ready <= ($urandom_range(99) >= recv_idle);
        else
            m_ready <= 1'b0;
    end

    task automatic send_beat(logic [1:0] op, logic [7:0] data);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        board.note_beat(op, data);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_beat(OP_ABSORB, 8'($urandom));
        send_beat(OP_FINISH, 8'($urandom));
    endtask

    task automatic random_phase(int count);
        int n;
        int r;
        int len;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 80) begin
                len = (r < 8) ? $urandom_range(110, 130) : $urandom_range(0, 70);
                if (len > count - n - 1) len = count - n - 1;
                send_message(len);
                n += len + 1;
                if ($urandom_range(3) == 0) begin
                    send_beat(OP_FINISH, 8'($urandom));
                    send_beat(OP_ABSORB, 8'($urandom));
                    n += 2;
                end
                if ($urandom_range(1)) begin
                    send_beat(OP_RESTART, 8'($urandom));
                    n++;
                end
            end else begin
                send_beat(2'($urandom), 8'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(OP_FINISH, 8'h00);
        send_beat(OP_FINISH, 8'hff);
        send_beat(OP_ABSORB, 8'hff);
        send_beat(OP_RESTART, 8'h00);
        send_beat(2'd3, 8'haa);
        send_beat(OP_ABSORB, 8'h00);
        send_beat(OP_ABSORB, 8'hff);
        send_beat(OP_ABSORB, 8'h55);
        send_beat(OP_FINISH, 8'h00);
        send_beat(OP_RESTART, 8'hff);
        for (int i = 0; i < 55; i++) send_beat(OP_ABSORB, 8'($urandom));
        send_beat(OP_FINISH, 8'h00);
        send_beat(OP_RESTART, 8'h00);
        for (int i = 0; i < 56; i++) send_beat(OP_ABSORB, 8'($urandom));
        send_beat(OP_FINISH, 8'h00);
        send_beat(OP_RESTART, 8'h00);
        for (int i = 0; i < 64; i++) send_beat(OP_ABSORB, 8'($urandom));
        send_beat(OP_FINISH, 8'h00);
        send_beat(OP_RESTART, 8'h00);

        send_idle = 19; recv_idle = 80;
        random_phase(60);
        drain();

        hold_off = 1'b1;
        fork
            begin
                send_beat(OP_FINISH, 8'h00);
                send_beat(OP_FINISH, 8'h00);
                send_beat(OP_FINISH, 8'h00);
                send_beat(OP_RESTART, 8'h00);
            end
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
        drain();

        send_idle = 80; recv_idle = 19;
        random_phase(60);
        drain();

        send_idle = 0; recv_idle = 0;
        random_phase(60);
        drain();

        repeat (400) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
